// ===== rtl/bate_pkg.sv =====
package bate_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [8:0] CAPACITY_RESET = 9'd256;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [4:0] CMD_APPEND  = 5'd0;
    localparam logic [4:0] CMD_INSERT  = 5'd1;
    localparam logic [4:0] CMD_DELETE  = 5'd2;
    localparam logic [4:0] CMD_SEARCH  = 5'd3;
    localparam logic [4:0] CMD_SRCH_TR = 5'd4;
    localparam logic [4:0] CMD_SRCH_FR = 5'd5;
    localparam logic [4:0] CMD_BSEARCH = 5'd6;
    localparam logic [4:0] CMD_GET     = 5'd7;
    localparam logic [4:0] CMD_SET     = 5'd8;
    localparam logic [4:0] CMD_MAX     = 5'd9;
    localparam logic [4:0] CMD_MIN     = 5'd10;
    localparam logic [4:0] CMD_SUM     = 5'd11;
    localparam logic [4:0] CMD_AVG     = 5'd12;
    localparam logic [4:0] CMD_REVERSE = 5'd13;
    localparam logic [4:0] CMD_ROT_L   = 5'd14;
    localparam logic [4:0] CMD_ROT_R   = 5'd15;
    localparam logic [4:0] CMD_SORTINS = 5'd16;
    localparam logic [4:0] CMD_CHECK   = 5'd17;
    localparam logic [4:0] CMD_PART    = 5'd18;

endpackage

// ===== rtl/bate_ifs.sv =====
interface bate_req_if;
    logic               valid;
    logic               ready;
    logic [4:0]         cmd;
    logic [9:0]         index_in;
    logic signed [31:0] value_in;

    modport source (output valid, cmd, index_in, value_in, input ready);
    modport sink (input valid, cmd, index_in, value_in, output ready);
endinterface

interface bate_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               found;
    logic [7:0]         position;
    logic signed [39:0] data_out;
    logic               is_sorted;
    logic [8:0]         count_out;

    modport source (output valid, status, found, position, data_out, is_sorted, count_out,
                    input ready);
    modport sink (input valid, status, found, position, data_out, is_sorted, count_out,
                  output ready);
endinterface

interface bate_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/bate_ram.sv =====
module bate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bate_div.sv =====
module bate_div #(
    parameter int NW  = 41,
    parameter int DVW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic [DVW-1:0]       divisor,
    output logic                 done,
    output logic signed [NW-1:0] quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  q_reg, q_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           neg_reg, neg_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DVW:0]   rem_sh;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, q_reg[NW-1]};
        if (start)
        begin
            neg_next  = dividend[NW-1];
            q_next    = dividend[NW-1] ? NW'(-dividend) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = DVW'(rem_sh - {1'b0, dvs_reg});
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVW-1:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ===== rtl/bounded_array_table_engine.sv =====
// Dense array engine over one simple dual-port RAM of DEPTH signed Q16.16 elements.
// One command is in flight at a time; req.ready is high only while no command is at
// work, and a finished result waits in an output register so the next command may
// start. Every array walk reads the RAM through its registered read port, one
// element at a time: searches, max, min, sum and the sorted check visit elements
// in order, insert, delete, rotate and sorted insert shift elements, reverse and
// partition swap pairs from both ends, binary search halves the range, and average
// then runs a divider that yields one quotient bit per cycle over DATA_WIDTH + count
// width bits. The RAM is not cleared: only entries below the element count are
// ever used. Capacity must be written on the cfg channel only while the block is
// idle; the block itself does not enforce this. Values above DEPTH act as DEPTH.
module bounded_array_table_engine #(
    parameter int DEPTH      = bate_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bate_pkg::DATA_WIDTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    bate_req_if.sink   req,
    bate_rsp_if.source rsp,
    bate_cfg_if.sink   cfg
);

    import bate_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = CW + 1;
    localparam int ACC_W = DW + CW;
    localparam int XW    = (CW > 9) ? CW : 9;
    localparam int IW    = (CW > 10) ? CW : 10;
    localparam int OW    = (ACC_W > 40) ? ACC_W : 40;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_INS_CHK, S_INS_USE, S_DEL_RD, S_ROTL_RD, S_ROTR_RD,
        S_SHL_CHK, S_SHL_USE, S_GET, S_SRCH_CHK, S_SRCH_USE, S_SWAP2,
        S_BS_CHK, S_BS_USE, S_WALK_CHK, S_WALK_USE, S_DIV, S_REV_CHK,
        S_REV1, S_REV2, S_REV3, S_PA, S_PA_USE, S_PB, S_PB_USE, S_PSW, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]            cmd_reg, cmd_next;
    logic [9:0]            idx_reg, idx_next;
    logic signed [DW-1:0]  val_reg, val_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [8:0]            cap_reg;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [CW-1:0]         stop_reg, stop_next;
    logic signed [BW-1:0]  bl_reg, bl_next;
    logic signed [BW-1:0]  bh_reg, bh_next;
    logic signed [DW-1:0]  tmp_reg, tmp_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]            status_reg, status_next;
    logic                  found_reg, found_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic signed [ACC_W-1:0] data_reg, data_next;
    logic                  sorted_reg, sorted_next;

    logic                  o_valid_reg, o_valid_next;
    logic [1:0]            o_status_reg, o_status_next;
    logic                  o_found_reg, o_found_next;
    logic [CW-1:0]         o_pos_reg, o_pos_next;
    logic signed [ACC_W-1:0] o_data_reg, o_data_next;
    logic                  o_sorted_reg, o_sorted_next;
    logic [CW-1:0]         o_count_reg, o_count_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DW-1:0]         ram_wdata, ram_rdata;
    logic signed [DW-1:0]  rd_s;

    logic                  div_start, div_done;
    logic signed [ACC_W-1:0] div_q;

    logic signed [63:0]    v64;
    logic [XW-1:0]         n_x, cap_x, depth_x, effcap;
    logic [IW-1:0]         n_i, idx_i;
    logic                  full;
    logic signed [BW:0]    bsum;
    logic [CW-1:0]         mid;
    logic [31:0]           pos32, cnt32;
    logic signed [OW-1:0]  dwide;

    function automatic logic [AW-1:0] adr(input logic [CW-1:0] x);
        return x[AW-1:0];
    endfunction

    assign rd_s    = ram_rdata;
    assign v64     = 64'(req.value_in);
    assign n_x     = XW'(count_reg);
    assign cap_x   = XW'(cap_reg);
    assign depth_x = XW'(DEPTH);
    assign effcap  = (cap_x > depth_x) ? depth_x : cap_x;
    assign full    = (n_x >= effcap);
    assign n_i     = IW'(count_reg);
    assign idx_i   = IW'(idx_reg);
    assign bsum    = (BW+1)'(bl_reg) + (BW+1)'(bh_reg);
    assign mid     = bsum[CW:1];

    bate_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bate_div #(
        .NW  (ACC_W),
        .DVW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        stop_next    = stop_reg;
        bl_next      = bl_reg;
        bh_next      = bh_reg;
        tmp_next     = tmp_reg;
        acc_next     = acc_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        data_next    = data_reg;
        sorted_next  = sorted_reg;
        o_valid_next = o_valid_reg && !rsp.ready;
        o_status_next = o_status_reg;
        o_found_next  = o_found_reg;
        o_pos_next    = o_pos_reg;
        o_data_next   = o_data_reg;
        o_sorted_next = o_sorted_reg;
        o_count_next  = o_count_reg;
        ram_we       = 1'b0;
        ram_waddr    = adr(i_reg);
        ram_wdata    = rd_s;
        ram_raddr    = adr(i_reg);
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    idx_next    = req.index_in;
                    val_next    = v64[DW-1:0];
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    data_next   = '0;
                    sorted_next = 1'b0;
                    acc_next    = '0;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                tmp_next   = val_reg;
                i_next     = '0;
                unique case (cmd_reg)
                    CMD_APPEND, CMD_INSERT, CMD_SORTINS:
                    begin
                        i_next = count_reg;
                        if (cmd_reg == CMD_INSERT)
                        begin
                            stop_next = CW'(idx_reg);
                        end
                        else if (cmd_reg == CMD_APPEND)
                        begin
                            stop_next = count_reg;
                        end
                        else
                        begin
                            stop_next = '0;
                        end
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (cmd_reg == CMD_INSERT && idx_i > n_i)
                        begin
                            status_next = ST_INDEX;
                        end
                        else
                        begin
                            state_next = S_INS_CHK;
                        end
                    end
                    CMD_DELETE, CMD_GET, CMD_SET:
                    begin
                        ram_raddr = adr(CW'(idx_reg));
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (idx_i >= n_i)
                        begin
                            status_next = ST_INDEX;
                        end
                        else if (cmd_reg == CMD_DELETE)
                        begin
                            state_next = S_DEL_RD;
                        end
                        else if (cmd_reg == CMD_GET)
                        begin
                            state_next = S_GET;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = adr(CW'(idx_reg));
                            ram_wdata = val_reg;
                        end
                    end
                    CMD_SEARCH, CMD_SRCH_TR, CMD_SRCH_FR:
                    begin
                        state_next = S_SRCH_CHK;
                    end
                    CMD_BSEARCH:
                    begin
                        bl_next    = '0;
                        bh_next    = BW'(count_reg) - BW'(1);
                        state_next = S_BS_CHK;
                    end
                    CMD_MAX, CMD_MIN, CMD_AVG:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_WALK_CHK;
                        end
                    end
                    CMD_SUM:
                    begin
                        state_next = S_WALK_CHK;
                    end
                    CMD_CHECK:
                    begin
                        sorted_next = 1'b1;
                        state_next  = S_WALK_CHK;
                    end
                    CMD_REVERSE:
                    begin
                        j_next     = count_reg - 1'b1;
                        state_next = S_REV_CHK;
                    end
                    CMD_ROT_L:
                    begin
                        ram_raddr = '0;
                        if (count_reg > CW'(1))
                        begin
                            state_next = S_ROTL_RD;
                        end
                    end
                    CMD_ROT_R:
                    begin
                        ram_raddr = adr(count_reg - 1'b1);
                        if (count_reg > CW'(1))
                        begin
                            state_next = S_ROTR_RD;
                        end
                    end
                    CMD_PART:
                    begin
                        j_next = count_reg - 1'b1;
                        if (count_reg > CW'(1))
                        begin
                            state_next = S_PA;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_INS_CHK:
            begin
                ram_raddr = adr(i_reg - 1'b1);
                if (i_reg == stop_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = tmp_reg;
                    if (cmd_reg != CMD_ROT_R)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (cmd_reg == CMD_SORTINS)
                    begin
                        pos_next = i_reg;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_INS_USE;
                end
            end
            S_INS_USE:
            begin
                ram_we = 1'b1;
                if (cmd_reg == CMD_SORTINS && val_reg > rd_s)
                begin
                    ram_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    pos_next   = i_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_wdata  = rd_s;
                    i_next     = i_reg - 1'b1;
                    state_next = S_INS_CHK;
                end
            end
            S_DEL_RD:
            begin
                data_next  = ACC_W'(rd_s);
                i_next     = CW'(idx_reg);
                state_next = S_SHL_CHK;
            end
            S_ROTL_RD:
            begin
                tmp_next   = rd_s;
                i_next     = '0;
                state_next = S_SHL_CHK;
            end
            S_ROTR_RD:
            begin
                tmp_next   = rd_s;
                i_next     = count_reg - 1'b1;
                stop_next  = '0;
                state_next = S_INS_CHK;
            end
            S_SHL_CHK:
            begin
                ram_raddr = adr(i_reg + 1'b1);
                if (i_reg + 1'b1 >= count_reg)
                begin
                    if (cmd_reg == CMD_DELETE)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = adr(count_reg - 1'b1);
                        ram_wdata = tmp_reg;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SHL_USE;
                end
            end
            S_SHL_USE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd_s;
                i_next     = i_reg + 1'b1;
                state_next = S_SHL_CHK;
            end
            S_GET:
            begin
                data_next  = ACC_W'(rd_s);
                state_next = S_FIN;
            end
            S_SRCH_CHK:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SRCH_USE;
                end
            end
            S_SRCH_USE:
            begin
                if (rd_s == val_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = i_reg;
                    state_next = S_FIN;
                    if (i_reg != '0 && cmd_reg == CMD_SRCH_TR)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = tmp_reg;
                        pos_next   = i_reg - 1'b1;
                        j_next     = i_reg - 1'b1;
                        state_next = S_SWAP2;
                    end
                    else if (i_reg != '0 && cmd_reg == CMD_SRCH_FR)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = tmp_reg;
                        pos_next   = '0;
                        j_next     = '0;
                        state_next = S_SWAP2;
                    end
                end
                else
                begin
                    if (cmd_reg != CMD_SRCH_FR || i_reg == '0)
                    begin
                        tmp_next = rd_s;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_SRCH_CHK;
                end
            end
            S_SWAP2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = adr(j_reg);
                ram_wdata  = val_reg;
                state_next = S_FIN;
            end
            S_BS_CHK:
            begin
                ram_raddr = adr(mid);
                i_next    = mid;
                if (bl_reg > bh_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_BS_USE;
                end
            end
            S_BS_USE:
            begin
                if (rd_s == val_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = i_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    if (val_reg < rd_s)
                    begin
                        bh_next = BW'(i_reg) - BW'(1);
                    end
                    else
                    begin
                        bl_next = BW'(i_reg) + BW'(1);
                    end
                    state_next = S_BS_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (i_reg >= count_reg)
                begin
                    if (cmd_reg == CMD_AVG)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_SUM)
                        begin
                            data_next = acc_reg;
                        end
                        else if (cmd_reg != CMD_CHECK)
                        begin
                            data_next = ACC_W'(tmp_reg);
                        end
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_WALK_USE;
                end
            end
            S_WALK_USE:
            begin
                acc_next = acc_reg + ACC_W'(rd_s);
                if (cmd_reg == CMD_CHECK)
                begin
                    if (i_reg != '0 && tmp_reg > rd_s)
                    begin
                        sorted_next = 1'b0;
                    end
                    tmp_next = rd_s;
                end
                else if (i_reg == '0 ||
                         (cmd_reg == CMD_MAX && rd_s > tmp_reg) ||
                         (cmd_reg == CMD_MIN && rd_s < tmp_reg))
                begin
                    tmp_next = rd_s;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_WALK_CHK;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    data_next  = div_q;
                    state_next = S_FIN;
                end
            end
            S_REV_CHK:
            begin
                if (i_reg >= (count_reg >> 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_REV1;
                end
            end
            S_REV1:
            begin
                tmp_next   = rd_s;
                ram_raddr  = adr(j_reg);
                state_next = S_REV2;
            end
            S_REV2:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd_s;
                state_next = S_REV3;
            end
            S_REV3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = adr(j_reg);
                ram_wdata  = tmp_reg;
                i_next     = i_reg + 1'b1;
                j_next     = j_reg - 1'b1;
                state_next = S_REV_CHK;
            end
            S_PA:
            begin
                state_next = (i_reg < j_reg) ? S_PA_USE : S_FIN;
            end
            S_PA_USE:
            begin
                if (rd_s < 0)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_PA;
                end
                else
                begin
                    tmp_next   = rd_s;
                    state_next = S_PB;
                end
            end
            S_PB:
            begin
                ram_raddr  = adr(j_reg);
                state_next = (i_reg < j_reg) ? S_PB_USE : S_FIN;
            end
            S_PB_USE:
            begin
                if (rd_s > 0)
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_PB;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = rd_s;
                    state_next = S_PSW;
                end
            end
            S_PSW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = adr(j_reg);
                ram_wdata  = tmp_reg;
                i_next     = i_reg + 1'b1;
                j_next     = j_reg - 1'b1;
                state_next = S_PA;
            end
            S_FIN:
            begin
                if (!o_valid_reg || rsp.ready)
                begin
                    o_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_found_next  = found_reg;
                    o_pos_next    = pos_reg;
                    o_data_next   = data_reg;
                    o_sorted_next = sorted_reg;
                    o_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAPACITY_RESET;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            o_valid_reg <= o_valid_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        stop_reg     <= stop_next;
        bl_reg       <= bl_next;
        bh_reg       <= bh_next;
        tmp_reg      <= tmp_next;
        acc_reg      <= acc_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        data_reg     <= data_next;
        sorted_reg   <= sorted_next;
        o_status_reg <= o_status_next;
        o_found_reg  <= o_found_next;
        o_pos_reg    <= o_pos_next;
        o_data_reg   <= o_data_next;
        o_sorted_reg <= o_sorted_next;
        o_count_reg  <= o_count_next;
    end

    assign pos32 = 32'(o_pos_reg);
    assign cnt32 = 32'(o_count_reg);
    assign dwide = OW'(o_data_reg);

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = o_valid_reg;
    assign rsp.status    = o_status_reg;
    assign rsp.found     = o_found_reg;
    assign rsp.position  = pos32[7:0];
    assign rsp.data_out  = dwide[39:0];
    assign rsp.is_sorted = o_sorted_reg;
    assign rsp.count_out = cnt32[8:0];

endmodule
